@@ rtl/thpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thpc_pkg: shared constants for the hello policy check
// Field widths, register indexes, verdict and list mode codes, and the
// fixed byte offsets of the hello messages.
// ----------------------------------------------------------------------------
package thpc_pkg;

    localparam int unsigned ID_BITS         = 16;
    localparam int unsigned ENTRY_BITS      = 3;
    localparam int unsigned CFG_DATA_BITS   = 64;
    localparam int unsigned CFG_INDEX_BITS  = 3;
    localparam int unsigned MODE_BITS       = 2;
    localparam int unsigned VERDICT_BITS    = 2;
    localparam int unsigned COUNT_BITS      = 4;

    localparam int unsigned LIST_ENTRIES_DEF  = 4;
    localparam int unsigned POSITION_BITS_DEF = 16;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_LIST_MODE      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CIPHER_WORDS   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CIPHER_ENTRIES = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLIENT_WORDS   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLIENT_ENTRIES = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SERVER_WORDS   = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SERVER_ENTRIES = 3'd6;

    // cipher list modes; anything above allow means unusable settings
    localparam logic [MODE_BITS-1:0] MODE_DENY     = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_ALLOW    = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_UNUSABLE = 2'd2;

    localparam logic [VERDICT_BITS-1:0] VERDICT_VALID   = 2'd0;
    localparam logic [VERDICT_BITS-1:0] VERDICT_INVALID = 2'd1;
    localparam logic [VERDICT_BITS-1:0] VERDICT_ERROR   = 2'd2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = 4'd15;

    // byte offsets inside the hello messages
    localparam int unsigned CLIENT_CIPHER_LEN_POS = 'h27;
    localparam int unsigned SERVER_CIPHER_POS     = 'h47;
    localparam int unsigned SERVER_EXT_POS        = 'h4c;

endpackage

`default_nettype wire

@@ rtl/thpc_list_match.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thpc_list_match: 16-bit id lookup in a short list
// Compares one id against every valid list entry in parallel and flags a hit.
// Entry counts above the list size act as a full list.
// ----------------------------------------------------------------------------
module thpc_list_match
    import thpc_pkg::*;
#(
    parameter int unsigned LIST_ENTRIES = LIST_ENTRIES_DEF
) (
    input  wire logic [ID_BITS-1:0]              id_value,
    input  wire logic [LIST_ENTRIES*ID_BITS-1:0] list_words,
    input  wire logic [ENTRY_BITS-1:0]           list_entries,
    output logic                                 hit
);

    always_comb begin
        hit = 1'b0;
        for (int i = 0; i < LIST_ENTRIES; i++) begin
            if ((ENTRY_BITS'(i) < list_entries) &&
                (list_words[i*ID_BITS +: ID_BITS] == id_value)) begin
                hit = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/tls_hello_policy_check_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tls_hello_policy_check_unit: client/server hello cipher and extension check
// Parses a client hello and then a server hello one byte per beat and gives
// one verdict per exchange, on the server hello's last byte.
// ----------------------------------------------------------------------------
// The block takes one message byte per clock cycle, back to back, and the
// verdict beat appears on the m_ side the cycle after the server hello's
// last byte is taken. All parsing of a byte (position compare, field
// pointer add and the three parallel 16-bit list compares) is done in
// the cycle that takes it, so the rate is one byte per cycle; the only
// stall is a verdict beat still waiting on m_ready. Configuration must be
// written while no exchange is in flight.
module tls_hello_policy_check_unit
    import thpc_pkg::*;
#(
    parameter int unsigned LIST_ENTRIES  = LIST_ENTRIES_DEF,
    parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,

    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      s_kind,
    input  wire logic [7:0]                s_data_byte,
    input  wire logic                      s_last_byte,

    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [VERDICT_BITS-1:0]        m_verdict,
    output logic [ID_BITS-1:0]             m_chosen_cipher,
    output logic [COUNT_BITS-1:0]          m_required_found,

    input  wire logic                      cfg_wr_en,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int unsigned POS_W   = POSITION_BITS + 1;
    localparam int unsigned NXT_W   = ((POSITION_BITS > ID_BITS) ? POSITION_BITS : ID_BITS) + 2;
    localparam int unsigned WORDS_W = LIST_ENTRIES * ID_BITS;

    localparam logic [POS_W-1:0] POS_LIMIT = {1'b1, {POSITION_BITS{1'b0}}};
    localparam logic [POS_W-1:0] POS_LAST  = {1'b0, {POSITION_BITS{1'b1}}};
    localparam logic [ENTRY_BITS-1:0] ENTRIES_MAX = ENTRY_BITS'(LIST_ENTRIES);

    typedef enum logic [3:0] {
        PH_C_LEN_HI   = 4'd0,
        PH_C_LEN_LO   = 4'd1,
        PH_C_COMP     = 4'd2,
        PH_C_WALK_T0  = 4'd3,
        PH_C_WALK_T1  = 4'd4,
        PH_C_WALK_L0  = 4'd5,
        PH_C_WALK_L1  = 4'd6,
        PH_C_DONE     = 4'd7,
        PH_S_CIPH_HI  = 4'd8,
        PH_S_CIPH_LO  = 4'd9,
        PH_S_WALK_T0  = 4'd10,
        PH_S_WALK_T1  = 4'd11,
        PH_S_WALK_L0  = 4'd12,
        PH_S_WALK_L1  = 4'd13
    } phase_t;

    // configuration
    logic [MODE_BITS-1:0]  list_mode_reg;
    logic [WORDS_W-1:0]    cipher_words_reg;
    logic [ENTRY_BITS-1:0] cipher_entries_reg;
    logic [WORDS_W-1:0]    client_words_reg;
    logic [ENTRY_BITS-1:0] client_entries_reg;
    logic [WORDS_W-1:0]    server_words_reg;
    logic [ENTRY_BITS-1:0] server_entries_reg;

    // parse state
    phase_t                  phase_reg, phase_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [NXT_W-1:0]        field_pos_reg, field_pos_next;
    logic [ID_BITS-1:0]      acc_reg, acc_next;
    logic [COUNT_BITS-1:0]   match_cnt_reg, match_cnt_next;
    logic [VERDICT_BITS-1:0] client_verdict_reg, client_verdict_next;
    logic [ID_BITS-1:0]      cipher_seen_reg, cipher_seen_next;
    logic [VERDICT_BITS-1:0] cipher_verdict_reg, cipher_verdict_next;
    logic                    pending_reg, pending_next;
    logic                    too_long_reg, too_long_next;

    // result register
    logic                    m_valid_reg, m_valid_next;
    logic [VERDICT_BITS-1:0] m_verdict_reg, m_verdict_next;
    logic [ID_BITS-1:0]      m_cipher_reg, m_cipher_next;
    logic [COUNT_BITS-1:0]   m_found_reg, m_found_next;

    logic                    accept;
    logic                    restart;
    logic [ID_BITS-1:0]      acc_eff;
    logic [ID_BITS-1:0]      pair_word;
    logic                    cipher_hit;
    logic                    client_hit;
    logic                    server_hit;
    logic [ENTRY_BITS-1:0]   client_need;
    logic [ENTRY_BITS-1:0]   server_need;
    logic [VERDICT_BITS-1:0] result_verdict;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // a client byte after a finished client hello, or a server byte before
    // the server hello started, opens a fresh message
    assign restart = s_kind ? (phase_reg <= PH_C_DONE) : (phase_reg >= PH_C_DONE);
    assign acc_eff   = restart ? '0 : acc_reg;
    assign pair_word = {acc_eff[7:0], s_data_byte};

    assign client_need = (client_entries_reg > ENTRIES_MAX) ? ENTRIES_MAX : client_entries_reg;
    assign server_need = (server_entries_reg > ENTRIES_MAX) ? ENTRIES_MAX : server_entries_reg;

    thpc_list_match #(.LIST_ENTRIES(LIST_ENTRIES)) u_cipher_match (
        .id_value     (pair_word),
        .list_words   (cipher_words_reg),
        .list_entries (cipher_entries_reg),
        .hit          (cipher_hit)
    );

    thpc_list_match #(.LIST_ENTRIES(LIST_ENTRIES)) u_client_match (
        .id_value     (pair_word),
        .list_words   (client_words_reg),
        .list_entries (client_entries_reg),
        .hit          (client_hit)
    );

    thpc_list_match #(.LIST_ENTRIES(LIST_ENTRIES)) u_server_match (
        .id_value     (pair_word),
        .list_words   (server_words_reg),
        .list_entries (server_entries_reg),
        .hit          (server_hit)
    );

    always_comb begin
        phase_next          = phase_reg;
        pos_next            = pos_reg;
        field_pos_next      = field_pos_reg;
        acc_next            = acc_reg;
        match_cnt_next      = match_cnt_reg;
        client_verdict_next = client_verdict_reg;
        cipher_seen_next    = cipher_seen_reg;
        cipher_verdict_next = cipher_verdict_reg;
        pending_next        = pending_reg;
        too_long_next       = too_long_reg;
        result_verdict      = VERDICT_VALID;

        m_valid_next   = m_valid_reg && !m_ready;
        m_verdict_next = m_verdict_reg;
        m_cipher_next  = m_cipher_reg;
        m_found_next   = m_found_reg;

        if (accept) begin
            if (restart) begin
                pos_next            = '0;
                acc_next            = '0;
                match_cnt_next      = '0;
                pending_next        = 1'b0;
                too_long_next       = 1'b0;
                cipher_seen_next    = '0;
                cipher_verdict_next = VERDICT_VALID;
                if (!s_kind) begin
                    phase_next          = PH_C_LEN_HI;
                    field_pos_next      = NXT_W'(CLIENT_CIPHER_LEN_POS);
                    client_verdict_next = VERDICT_VALID;
                end else begin
                    phase_next     = PH_S_CIPH_HI;
                    field_pos_next = NXT_W'(SERVER_CIPHER_POS);
                    // client hello cut short by the server hello
                    if (phase_reg != PH_C_DONE) begin
                        client_verdict_next = VERDICT_ERROR;
                    end
                end
            end

            if (pos_next >= POS_LAST) begin
                too_long_next = 1'b1;
            end

            if (NXT_W'(pos_next) == field_pos_next) begin
                unique case (phase_next)
                    PH_C_LEN_HI: begin
                        acc_next       = ID_BITS'(s_data_byte);
                        field_pos_next = field_pos_next + NXT_W'(1);
                        phase_next     = PH_C_LEN_LO;
                    end
                    PH_S_CIPH_HI: begin
                        acc_next       = ID_BITS'(s_data_byte);
                        field_pos_next = field_pos_next + NXT_W'(1);
                        phase_next     = PH_S_CIPH_LO;
                    end
                    PH_C_LEN_LO: begin
                        // skip the cipher list
                        acc_next       = pair_word;
                        field_pos_next = field_pos_next + NXT_W'(1) + NXT_W'(pair_word);
                        phase_next     = PH_C_COMP;
                    end
                    PH_C_COMP: begin
                        // skip compression list and extension-list length
                        field_pos_next = field_pos_next + NXT_W'(3) + NXT_W'(s_data_byte);
                        phase_next     = PH_C_WALK_T0;
                    end
                    PH_S_CIPH_LO: begin
                        cipher_seen_next = pair_word;
                        case (list_mode_reg)
                            MODE_DENY:  cipher_verdict_next = cipher_hit ? VERDICT_INVALID
                                                                         : VERDICT_VALID;
                            MODE_ALLOW: cipher_verdict_next = cipher_hit ? VERDICT_VALID
                                                                         : VERDICT_INVALID;
                            default:    cipher_verdict_next = VERDICT_ERROR;
                        endcase
                        field_pos_next = NXT_W'(SERVER_EXT_POS);
                        phase_next     = PH_S_WALK_T0;
                    end
                    PH_C_WALK_T0, PH_C_WALK_L0, PH_S_WALK_T0, PH_S_WALK_L0: begin
                        acc_next       = ID_BITS'(s_data_byte);
                        field_pos_next = field_pos_next + NXT_W'(1);
                        phase_next     = phase_t'(phase_next + 4'd1);
                    end
                    PH_C_WALK_T1, PH_S_WALK_T1: begin
                        acc_next       = pair_word;
                        pending_next   = (phase_next == PH_C_WALK_T1) ? client_hit : server_hit;
                        field_pos_next = field_pos_next + NXT_W'(1);
                        phase_next     = phase_t'(phase_next + 4'd1);
                    end
                    PH_C_WALK_L1, PH_S_WALK_L1: begin
                        // count a listed extension and jump over its body
                        acc_next = pair_word;
                        if (pending_next && (match_cnt_next < COUNT_MAX)) begin
                            match_cnt_next = match_cnt_next + COUNT_BITS'(1);
                        end
                        pending_next   = 1'b0;
                        field_pos_next = field_pos_next + NXT_W'(1) + NXT_W'(pair_word);
                        phase_next     = (phase_next == PH_C_WALK_L1) ? PH_C_WALK_T0
                                                                      : PH_S_WALK_T0;
                    end
                    default: begin
                    end
                endcase
            end

            if (pos_next < POS_LIMIT) begin
                pos_next = pos_next + POS_W'(1);
            end

            if (s_last_byte) begin
                if (!s_kind) begin
                    if (too_long_next || (phase_next < PH_C_WALK_T0)) begin
                        client_verdict_next = VERDICT_ERROR;
                    end else if (match_cnt_next >= COUNT_BITS'(client_need)) begin
                        client_verdict_next = VERDICT_VALID;
                    end else begin
                        client_verdict_next = VERDICT_INVALID;
                    end
                    phase_next = PH_C_DONE;
                    pos_next   = '0;
                end else begin
                    if (list_mode_reg >= MODE_UNUSABLE) begin
                        result_verdict = VERDICT_ERROR;
                    end else if (client_verdict_next != VERDICT_VALID) begin
                        result_verdict = client_verdict_next;
                    end else if (too_long_next || (phase_next < PH_S_WALK_T0)) begin
                        result_verdict = VERDICT_ERROR;
                    end else if (cipher_verdict_next != VERDICT_VALID) begin
                        result_verdict = cipher_verdict_next;
                    end else if (match_cnt_next >= COUNT_BITS'(server_need)) begin
                        result_verdict = VERDICT_VALID;
                    end else begin
                        result_verdict = VERDICT_INVALID;
                    end

                    m_valid_next   = 1'b1;
                    m_verdict_next = result_verdict;
                    m_cipher_next  = cipher_seen_next;
                    m_found_next   = match_cnt_next;

                    // back to waiting for a client hello
                    phase_next          = PH_C_LEN_HI;
                    pos_next            = '0;
                    field_pos_next      = NXT_W'(CLIENT_CIPHER_LEN_POS);
                    acc_next            = '0;
                    match_cnt_next      = '0;
                    pending_next        = 1'b0;
                    too_long_next       = 1'b0;
                    client_verdict_next = VERDICT_VALID;
                    cipher_seen_next    = '0;
                    cipher_verdict_next = VERDICT_VALID;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            list_mode_reg      <= MODE_UNUSABLE;
            cipher_words_reg   <= '0;
            cipher_entries_reg <= '0;
            client_words_reg   <= '0;
            client_entries_reg <= '0;
            server_words_reg   <= '0;
            server_entries_reg <= '0;
            phase_reg          <= PH_C_LEN_HI;
            pos_reg            <= '0;
            field_pos_reg      <= NXT_W'(CLIENT_CIPHER_LEN_POS);
            acc_reg            <= '0;
            match_cnt_reg      <= '0;
            client_verdict_reg <= VERDICT_VALID;
            cipher_seen_reg    <= '0;
            cipher_verdict_reg <= VERDICT_VALID;
            pending_reg        <= 1'b0;
            too_long_reg       <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_LIST_MODE:      list_mode_reg      <= cfg_data[MODE_BITS-1:0];
                    REG_CIPHER_WORDS:   cipher_words_reg   <= cfg_data[WORDS_W-1:0];
                    REG_CIPHER_ENTRIES: cipher_entries_reg <= cfg_data[ENTRY_BITS-1:0];
                    REG_CLIENT_WORDS:   client_words_reg   <= cfg_data[WORDS_W-1:0];
                    REG_CLIENT_ENTRIES: client_entries_reg <= cfg_data[ENTRY_BITS-1:0];
                    REG_SERVER_WORDS:   server_words_reg   <= cfg_data[WORDS_W-1:0];
                    REG_SERVER_ENTRIES: server_entries_reg <= cfg_data[ENTRY_BITS-1:0];
                    default: begin
                    end
                endcase
            end
            phase_reg          <= phase_next;
            pos_reg            <= pos_next;
            field_pos_reg      <= field_pos_next;
            acc_reg            <= acc_next;
            match_cnt_reg      <= match_cnt_next;
            client_verdict_reg <= client_verdict_next;
            cipher_seen_reg    <= cipher_seen_next;
            cipher_verdict_reg <= cipher_verdict_next;
            pending_reg        <= pending_next;
            too_long_reg       <= too_long_next;
            m_valid_reg        <= m_valid_next;
        end
        m_verdict_reg <= m_verdict_next;
        m_cipher_reg  <= m_cipher_next;
        m_found_reg   <= m_found_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_verdict        = m_verdict_reg;
    assign m_chosen_cipher  = m_cipher_reg;
    assign m_required_found = m_found_reg;

`ifndef SYNTH
    // a verdict beat only follows the last byte of a server hello
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(accept && s_kind && s_last_byte))
        else $error("verdict raised without a server hello last byte");

    // after a verdict the parser waits for a fresh client hello
    a_restart_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_kind && s_last_byte) |=> (phase_reg == PH_C_LEN_HI && pos_reg == '0))
        else $error("parser did not restart after the verdict");

    // a finished client hello parks the parser
    a_client_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_kind && s_last_byte) |=> (phase_reg == PH_C_DONE && pos_reg == '0))
        else $error("client hello end not recorded");

    // unusable settings always give an error verdict
    a_unusable_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_kind && s_last_byte && list_mode_reg >= MODE_UNUSABLE)
            |=> (m_valid && m_verdict == VERDICT_ERROR))
        else $error("unusable settings did not force an error verdict");
`endif

endmodule

`default_nettype wire
